// ===== hw/rtl/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// Shared constants and types of the 16-bit integer matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM = 8;

  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 32;
  localparam int POS_W   = 3;
  localparam int INDEX_W = 6;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

endpackage

// ===== hw/rtl/int16_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// int16_matrix_multiply
// Loads matrices A and B into two RAMs and streams out C = A * B row-major.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  s_*      | in        | load of one A or B element, or a compute request
//  m_*      | out       | one element of C, tlast on the final element
//  cfg_*    | in        | write of rows, inner or cols
//
// A compute issues rows*cols*inner reads of A and B, one per cycle while the
// output is not stalled; they pass the RAM read, product and output registers.
// Reset clears control state only; RAM contents are undefined until loaded.
// A stalled output register freezes the whole read and multiply pipeline.
// The input is not ready while a compute is issuing its reads.
module int16_matrix_multiply #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // index[5:0], value[21:6], zero[23:22]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // product[31:0], row[34:32], col[37:35], zero[39:38]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CNT_W  = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
  localparam int LIN_W  = 2 * DIM_W;

  imm_pkg::state_t state;

  logic [DIM_W-1:0] dim_m;
  logic [DIM_W-1:0] dim_k;
  logic [DIM_W-1:0] dim_n;
  logic [DIM_W-1:0] cfg_dim;

  logic [CNT_W-1:0] r;
  logic [CNT_W-1:0] c;
  logic [CNT_W-1:0] t;

  logic s_fire;
  logic adv;
  logic issue;
  logic t_end;
  logic c_end;
  logic r_end;

  logic [imm_pkg::KIND_W-1:0]  in_kind;
  logic [imm_pkg::INDEX_W-1:0] in_index;
  logic [imm_pkg::ELEM_W-1:0]  in_value;
  logic                        load_ok;
  logic                        we_a;
  logic                        we_b;

  logic [LIN_W-1:0] a_lin;
  logic [LIN_W-1:0] b_lin;

  logic [imm_pkg::ELEM_W-1:0] a_rd;
  logic [imm_pkg::ELEM_W-1:0] b_rd;

  logic signed [imm_pkg::PROD_W-1:0] prod1;

  logic             v1;
  logic             first1;
  logic             tlast1;
  logic             elast1;
  logic [CNT_W-1:0] row1;
  logic [CNT_W-1:0] col1;

  logic                       v2;
  logic                       first2;
  logic                       tlast2;
  logic                       elast2;
  logic [CNT_W-1:0]           row2;
  logic [CNT_W-1:0]           col2;
  logic [imm_pkg::PROD_W-1:0] prod2;

  logic [imm_pkg::PROD_W-1:0] acc;
  logic [imm_pkg::PROD_W-1:0] acc_next;

  logic [imm_pkg::PROD_W-1:0] out_product;
  logic [imm_pkg::POS_W-1:0]  out_row;
  logic [imm_pkg::POS_W-1:0]  out_col;
  logic                       out_last;

  assign in_kind  = s_tuser;
  assign in_index = s_tdata[5:0];
  assign in_value = s_tdata[21:6];

  assign s_tready  = (state == imm_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign s_fire    = s_tvalid && s_tready;

  assign adv   = !(m_tvalid && !m_tready);
  assign issue = (state == imm_pkg::ST_RUN) && adv;

  assign t_end = (DIM_W'(t) == dim_k - DIM_W'(1));
  assign c_end = (DIM_W'(c) == dim_n - DIM_W'(1));
  assign r_end = (DIM_W'(r) == dim_m - DIM_W'(1));

  assign load_ok = ({1'b0, in_index} < (imm_pkg::INDEX_W + 1)'(DEPTH));
  assign we_a    = s_fire && (in_kind == imm_pkg::KIND_LOAD_A) && load_ok;
  assign we_b    = s_fire && (in_kind == imm_pkg::KIND_LOAD_B) && load_ok;

  assign a_lin = LIN_W'(r) * LIN_W'(dim_k) + LIN_W'(t);
  assign b_lin = LIN_W'(t) * LIN_W'(dim_n) + LIN_W'(c);

  always_comb begin
    cfg_dim = DIM_W'(cfg_data);
    if (cfg_data == '0) begin
      cfg_dim = DIM_W'(1);
    end else if ({1'b0, cfg_data} > (imm_pkg::CFG_W + 1)'(MAX_DIM)) begin
      cfg_dim = DIM_W'(MAX_DIM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_m <= DIM_W'(MAX_DIM);
      dim_k <= DIM_W'(MAX_DIM);
      dim_n <= DIM_W'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        imm_pkg::REG_ROWS:  dim_m <= cfg_dim;
        imm_pkg::REG_INNER: dim_k <= cfg_dim;
        imm_pkg::REG_COLS:  dim_n <= cfg_dim;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imm_pkg::ST_IDLE;
      r     <= '0;
      c     <= '0;
      t     <= '0;
    end else begin
      case (state)
        imm_pkg::ST_IDLE: begin
          if (s_fire && in_kind == imm_pkg::KIND_COMPUTE) begin
            state <= imm_pkg::ST_RUN;
            r     <= '0;
            c     <= '0;
            t     <= '0;
          end
        end
        imm_pkg::ST_RUN: begin
          if (adv) begin
            if (!t_end) begin
              t <= t + CNT_W'(1);
            end else begin
              t <= '0;
              if (!c_end) begin
                c <= c + CNT_W'(1);
              end else begin
                c <= '0;
                if (r_end) begin
                  state <= imm_pkg::ST_IDLE;
                end else begin
                  r <= r + CNT_W'(1);
                end
              end
            end
          end
        end
        default: state <= imm_pkg::ST_IDLE;
      endcase
    end
  end

  imm_ram #(
    .WIDTH(imm_pkg::ELEM_W),
    .DEPTH(DEPTH)
  ) u_a_store (
    .clk  (clk),
    .we   (we_a),
    .waddr(in_index[ADDR_W-1:0]),
    .wdata(in_value),
    .re   (adv),
    .raddr(a_lin[ADDR_W-1:0]),
    .rdata(a_rd)
  );

  imm_ram #(
    .WIDTH(imm_pkg::ELEM_W),
    .DEPTH(DEPTH)
  ) u_b_store (
    .clk  (clk),
    .we   (we_b),
    .waddr(in_index[ADDR_W-1:0]),
    .wdata(in_value),
    .re   (adv),
    .raddr(b_lin[ADDR_W-1:0]),
    .rdata(b_rd)
  );

  assign prod1 = $signed(a_rd) * $signed(b_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first1 <= (t == '0);
      tlast1 <= t_end;
      elast1 <= r_end && c_end;
      row1   <= r;
      col1   <= c;
      first2 <= first1;
      tlast2 <= tlast1;
      elast2 <= elast1;
      row2   <= row1;
      col2   <= col1;
      prod2  <= prod1;
    end
  end

  assign acc_next = first2 ? prod2 : acc + prod2;

  always_ff @(posedge clk) begin
    if (adv && v2) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v2 && tlast2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2 && tlast2) begin
      out_product <= acc_next;
      out_row     <= imm_pkg::POS_W'(row2);
      out_col     <= imm_pkg::POS_W'(col2);
      out_last    <= elast2;
    end
  end

  assign m_tdata = {2'b00, out_col, out_row, out_product};
  assign m_tlast = out_last;

endmodule

// ===== hw/rtl/imm_ram.sv =====
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/imm_checker.sv =====
// ----------------------------------------------------------------------------
// imm_checker
// Port-level checks of the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module imm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Stalled output transaction changed.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output valid after reset.");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == imm_pkg::KIND_COMPUTE |=> !s_tready)
    else $error("Input ready right after a compute transaction.");

endmodule

bind int16_matrix_multiply imm_checker u_imm_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

// ===== dv/int16_matrix_multiply_chk.sv =====
// ----------------------------------------------------------------------------
// int16_matrix_multiply_chk
// Watches the load, configuration and result channels of the matrix
// multiplier. It keeps its own copy of both element stores and of the three
// dimension registers, predicts every element of C when a compute transaction
// is accepted, and compares each result transaction in order.
// ----------------------------------------------------------------------------
module int16_matrix_multiply_chk
  import imm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [23:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [39:0]          m_tdata,
  input  logic                 m_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PROD_W-1:0] product;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              last;
  } c_elem_t;

  c_elem_t           c_elements_q[$];
  logic [ELEM_W-1:0] a_mem[MAX_DIM*MAX_DIM];
  logic [ELEM_W-1:0] b_mem[MAX_DIM*MAX_DIM];
  logic [CFG_W-1:0]  rows_reg;
  logic [CFG_W-1:0]  inner_reg;
  logic [CFG_W-1:0]  cols_reg;

  function automatic int clamp_dim(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void predict_matrix();
    int                       m;
    int                       k;
    int                       n;
    int                       term;
    logic signed [PROD_W-1:0] acc;
    c_elem_t                  elem;
    m = clamp_dim(rows_reg);
    k = clamp_dim(inner_reg);
    n = clamp_dim(cols_reg);
    for (int r = 0; r < m; r++) begin
      for (int c = 0; c < n; c++) begin
        acc = '0;
        for (int t = 0; t < k; t++) begin
          term = $signed(a_mem[(r * k + t) % (MAX_DIM * MAX_DIM)])
               * $signed(b_mem[(t * n + c) % (MAX_DIM * MAX_DIM)]);
          acc = acc + term;
        end
        elem.product = acc;
        elem.row     = r[POS_W-1:0];
        elem.col     = c[POS_W-1:0];
        elem.last    = (r == m - 1) && (c == n - 1);
        c_elements_q.push_back(elem);
      end
    end
  endfunction

  always @(posedge clk) begin : monitor
    c_elem_t got;
    c_elem_t want;
    if (rst) begin
      rows_reg  = 4'd8;
      inner_reg = 4'd8;
      cols_reg  = 4'd8;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS:  rows_reg  = cfg_data;
          REG_INNER: inner_reg = cfg_data;
          REG_COLS:  cols_reg  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          KIND_LOAD_A:  a_mem[s_tdata[INDEX_W-1:0]] = s_tdata[INDEX_W +: ELEM_W];
          KIND_LOAD_B:  b_mem[s_tdata[INDEX_W-1:0]] = s_tdata[INDEX_W +: ELEM_W];
          KIND_COMPUTE: predict_matrix();
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.product = m_tdata[PROD_W-1:0];
        got.row     = m_tdata[PROD_W +: POS_W];
        got.col     = m_tdata[PROD_W + POS_W +: POS_W];
        got.last    = m_tlast;
        if (c_elements_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected C element product %0d row %0d col %0d last %0b",
                     $time, $signed(got.product), got.row, got.col, got.last);
        end else begin
          want = c_elements_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: C element mismatch, expected product %0d row %0d col %0d",
                        " last %0b, got product %0d row %0d col %0d last %0b"},
                       $time, $signed(want.product), want.row, want.col, want.last,
                       $signed(got.product), got.row, got.col, got.last);
          end
        end
      end
    end
    pending <= c_elements_q.size();
  end

endmodule

// ===== dv/int16_matrix_multiply_tb.sv =====
// ----------------------------------------------------------------------------
// int16_matrix_multiply_tb
// Drives loads of A and B, dimension writes and compute requests into the
// matrix multiplier, with random gaps on the input and random stalls on the
// output. A directed opening covers wraparound, clamped dimensions, ignored
// kinds and the largest result runs; random phases with refilled operands
// follow. The checker beside the block reports the failures counted.
// ----------------------------------------------------------------------------
module int16_matrix_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import imm_pkg::*;

  localparam logic [KIND_W-1:0]    KIND_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;
  localparam int                   STORE_DEPTH   = MAX_DIM * MAX_DIM;
  localparam int                   ITEM_TARGET   = 280;
  localparam int                   IDLE_PCT      = 6;
  localparam int                   HOLD_CYCLES   = 300;
  localparam int                   SETTLE_CYCLES = 10;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata   = '0;
  logic [1:0]           s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [39:0]          m_tdata;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int               errors;
  int               pending;
  int               items_sent = 0;
  bit               calm       = 1'b0;
  bit               hold_req   = 1'b0;
  bit               a_loaded[STORE_DEPTH];
  bit               b_loaded[STORE_DEPTH];
  logic [CFG_W-1:0] dim_rows   = 4'd8;
  logic [CFG_W-1:0] dim_inner  = 4'd8;
  logic [CFG_W-1:0] dim_cols   = 4'd8;

  int16_matrix_multiply dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  int16_matrix_multiply_chk matrix_chk (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  function automatic int eff_dim(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return 4'd8;
    if (pick < 13) return 4'd0;
    if (pick < 18) return 4'($urandom_range(15, 9));
    return 4'($urandom_range(4, 1));
  endfunction

  task automatic send_item(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] index,
                           logic [ELEM_W-1:0] value);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, value, index};
    do @(posedge clk); while (!s_tready);
    if (kind == KIND_LOAD_A) a_loaded[index] = 1'b1;
    else if (kind == KIND_LOAD_B) b_loaded[index] = 1'b1;
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // Every operand entry that the current dimensions read is loaded first.
  task automatic issue_compute();
    int a_need;
    int b_need;
    a_need = eff_dim(dim_rows) * eff_dim(dim_inner);
    b_need = eff_dim(dim_inner) * eff_dim(dim_cols);
    for (int i = 0; i < a_need; i++)
      if (!a_loaded[i]) send_item(KIND_LOAD_A, i[INDEX_W-1:0], rand_elem());
    for (int i = 0; i < b_need; i++)
      if (!b_loaded[i]) send_item(KIND_LOAD_B, i[INDEX_W-1:0], rand_elem());
    send_item(KIND_COMPUTE, 6'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_dims(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] n);
    wait_idle();
    write_reg(REG_ROWS, r);
    write_reg(REG_INNER, k);
    write_reg(REG_COLS, n);
    cfg_valid <= 1'b0;
    dim_rows  = r;
    dim_inner = k;
    dim_cols  = n;
  endtask

  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    int                 a_span;
    int                 b_span;
    bit                 pick_b;
    logic [INDEX_W-1:0] idx;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // A 1x2 by 2x1 product of the most negative values wraps to the sign bit.
    set_dims(4'd1, 4'd2, 4'd1);
    send_item(KIND_LOAD_A, 6'd0, 16'h8000);
    send_item(KIND_LOAD_A, 6'd1, 16'h8000);
    send_item(KIND_LOAD_B, 6'd0, 16'h8000);
    send_item(KIND_LOAD_B, 6'd1, 16'h8000);
    issue_compute();
    send_item(KIND_LOAD_A, 6'd63, 16'h7fff);
    send_item(KIND_LOAD_B, 6'd63, 16'hffff);
    send_item(KIND_UNUSED, 6'd63, 16'hffff);

    set_dims(4'd0, 4'd15, 4'd0);
    @(posedge clk);
    write_reg(REG_UNUSED, 4'd15);
    cfg_valid <= 1'b0;
    issue_compute();

    set_dims(4'd8, 4'd1, 4'd8);
    issue_compute();

    set_dims(4'd2, 4'd3, 4'd2);
    issue_compute();
    send_item(KIND_UNUSED, 6'($urandom), 16'($urandom));
    issue_compute();

    // The output holds off long enough for the compute to back up the input.
    set_dims(4'd8, 4'd2, 4'd8);
    hold_req = 1'b1;
    issue_compute();
    send_item(KIND_LOAD_A, 6'($urandom_range(15)), rand_elem());
    send_item(KIND_LOAD_B, 6'($urandom_range(15)), rand_elem());
    issue_compute();

    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= 150) && (items_sent < 200);
      if ($urandom_range(99) < 30) set_dims(rand_dim(), rand_dim(), rand_dim());
      a_span = eff_dim(dim_rows) * eff_dim(dim_inner);
      b_span = eff_dim(dim_inner) * eff_dim(dim_cols);
      repeat ($urandom_range(10)) begin
        pick_b = 1'($urandom_range(1));
        if ($urandom_range(99) < 75)
          idx = 6'($urandom_range((pick_b ? b_span : a_span) - 1));
        else
          idx = 6'($urandom_range(STORE_DEPTH - 1));
        send_item(pick_b ? KIND_LOAD_B : KIND_LOAD_A, idx, rand_elem());
      end
      if ($urandom_range(99) < 10) send_item(KIND_UNUSED, 6'($urandom), 16'($urandom));
      if ($urandom_range(99) < 85) issue_compute();
      if ($urandom_range(99) < 20) issue_compute();
    end
    calm = 1'b0;

    wait_idle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
